>>> sv/battery_charge_state_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// battery charge state tracker assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_STATE_TRACKER_TOP_ASSERT_SVH
`define BATTERY_CHARGE_STATE_TRACKER_TOP_ASSERT_SVH

// clocked property, muted while reset is asserted
`define BCST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked property, checked during reset as well
`define BCST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/bcst_pkg.sv
// ----------------------------------------------------------------------------
// bcst_pkg
// shared types, constants and the charge curve table of the tracker
// ----------------------------------------------------------------------------
`default_nettype none

package bcst_pkg;

  // field widths
  localparam int MV_W   = 14;
  localparam int PCT_W  = 7;
  localparam int CST_W  = 2;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 32;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  // curve table geometry
  localparam int CURVE_SLOTS      = 64;
  localparam int CURVE_POINTS_DEF = 21;
  localparam int IDX_W            = $clog2(CURVE_SLOTS);

  // interpolation: product of mv and percent spans, quotient below 2**PCT_W
  localparam int PROD_W    = MV_W + PCT_W;
  localparam int DIV_STEPS = PCT_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  // register map
  localparam logic [2:0] REG_USB_PRESENT = 3'd0;
  localparam logic [2:0] REG_BAT_MIN     = 3'd1;
  localparam logic [2:0] REG_BAT_MAX     = 3'd2;
  localparam logic [2:0] REG_LOW_PCT     = 3'd3;
  localparam logic [2:0] REG_CRIT_PCT    = 3'd4;
  localparam logic [2:0] REG_START_CAP   = 3'd5;

  // register reset values
  localparam logic [MV_W-1:0]  RST_USB_PRESENT = MV_W'(4000);
  localparam logic [MV_W-1:0]  RST_BAT_MIN     = MV_W'(2500);
  localparam logic [MV_W-1:0]  RST_BAT_MAX     = MV_W'(4600);
  localparam logic [PCT_W-1:0] RST_LOW_PCT     = PCT_W'(20);
  localparam logic [PCT_W-1:0] RST_CRIT_PCT    = PCT_W'(10);
  localparam logic [PCT_W-1:0] RST_START_CAP   = PCT_W'(95);

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2
  } charge_cmd_e;

  typedef enum logic [CST_W-1:0] {
    CHG_IDLE = 2'd0,
    CHG_PRE  = 2'd1,
    CHG_FAST = 2'd2,
    CHG_DONE = 2'd3
  } charger_state_e;

  typedef struct packed {
    logic [MV_W-1:0]  usb_present_mv;
    logic [MV_W-1:0]  battery_min_mv;
    logic [MV_W-1:0]  battery_max_mv;
    logic [PCT_W-1:0] low_percent;
    logic [PCT_W-1:0] critical_percent;
    logic [PCT_W-1:0] charge_start_cap;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic search;
    logic div_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic edge_hit;
    logic seg_hit;
    logic seg_simple;
    logic seg_last;
    logic div_last;
    logic out_free;
  } sts_t;

  // curve voltage points, descending; unused slots read zero
  function automatic logic [MV_W-1:0] curve_mv(input logic [IDX_W-1:0] idx);
    logic [MV_W-1:0] v;
    case (idx)
      6'd0:  v = MV_W'(4200);
      6'd1:  v = MV_W'(4150);
      6'd2:  v = MV_W'(4110);
      6'd3:  v = MV_W'(4080);
      6'd4:  v = MV_W'(4020);
      6'd5:  v = MV_W'(3980);
      6'd6:  v = MV_W'(3950);
      6'd7:  v = MV_W'(3910);
      6'd8:  v = MV_W'(3870);
      6'd9:  v = MV_W'(3850);
      6'd10: v = MV_W'(3820);
      6'd11: v = MV_W'(3800);
      6'd12: v = MV_W'(3780);
      6'd13: v = MV_W'(3760);
      6'd14: v = MV_W'(3740);
      6'd15: v = MV_W'(3710);
      6'd16: v = MV_W'(3680);
      6'd17: v = MV_W'(3650);
      6'd18: v = MV_W'(3600);
      6'd19: v = MV_W'(3500);
      6'd20: v = MV_W'(3300);
      default: v = '0;
    endcase
    return v;
  endfunction

  // curve percent points matching curve_mv
  function automatic logic [PCT_W-1:0] curve_pct(input logic [IDX_W-1:0] idx);
    logic [PCT_W-1:0] p;
    case (idx)
      6'd0:  p = PCT_W'(100);
      6'd1:  p = PCT_W'(95);
      6'd2:  p = PCT_W'(90);
      6'd3:  p = PCT_W'(85);
      6'd4:  p = PCT_W'(80);
      6'd5:  p = PCT_W'(75);
      6'd6:  p = PCT_W'(70);
      6'd7:  p = PCT_W'(65);
      6'd8:  p = PCT_W'(60);
      6'd9:  p = PCT_W'(55);
      6'd10: p = PCT_W'(50);
      6'd11: p = PCT_W'(45);
      6'd12: p = PCT_W'(40);
      6'd13: p = PCT_W'(35);
      6'd14: p = PCT_W'(30);
      6'd15: p = PCT_W'(25);
      6'd16: p = PCT_W'(20);
      6'd17: p = PCT_W'(15);
      6'd18: p = PCT_W'(10);
      6'd19: p = PCT_W'(5);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> sv/bcst_regs.sv
// ----------------------------------------------------------------------------
// bcst_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
`default_nettype none

module bcst_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bcst_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bcst_pkg::DATA_W-1:0] pwdata,
  output logic      [bcst_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output bcst_pkg::cfg_t                   cfg_o
);

  bcst_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.usb_present_mv   <= bcst_pkg::RST_USB_PRESENT;
      cfg_q.battery_min_mv   <= bcst_pkg::RST_BAT_MIN;
      cfg_q.battery_max_mv   <= bcst_pkg::RST_BAT_MAX;
      cfg_q.low_percent      <= bcst_pkg::RST_LOW_PCT;
      cfg_q.critical_percent <= bcst_pkg::RST_CRIT_PCT;
      cfg_q.charge_start_cap <= bcst_pkg::RST_START_CAP;
    end else if (wr_en) begin
      case (reg_sel)
        bcst_pkg::REG_USB_PRESENT: cfg_q.usb_present_mv   <= pwdata[bcst_pkg::MV_W-1:0];
        bcst_pkg::REG_BAT_MIN:     cfg_q.battery_min_mv   <= pwdata[bcst_pkg::MV_W-1:0];
        bcst_pkg::REG_BAT_MAX:     cfg_q.battery_max_mv   <= pwdata[bcst_pkg::MV_W-1:0];
        bcst_pkg::REG_LOW_PCT:     cfg_q.low_percent      <= pwdata[bcst_pkg::PCT_W-1:0];
        bcst_pkg::REG_CRIT_PCT:    cfg_q.critical_percent <= pwdata[bcst_pkg::PCT_W-1:0];
        bcst_pkg::REG_START_CAP:   cfg_q.charge_start_cap <= pwdata[bcst_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      bcst_pkg::REG_USB_PRESENT: prdata = bcst_pkg::DATA_W'(cfg_q.usb_present_mv);
      bcst_pkg::REG_BAT_MIN:     prdata = bcst_pkg::DATA_W'(cfg_q.battery_min_mv);
      bcst_pkg::REG_BAT_MAX:     prdata = bcst_pkg::DATA_W'(cfg_q.battery_max_mv);
      bcst_pkg::REG_LOW_PCT:     prdata = bcst_pkg::DATA_W'(cfg_q.low_percent);
      bcst_pkg::REG_CRIT_PCT:    prdata = bcst_pkg::DATA_W'(cfg_q.critical_percent);
      bcst_pkg::REG_START_CAP:   prdata = bcst_pkg::DATA_W'(cfg_q.charge_start_cap);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> sv/bcst_ctrl.sv
// ----------------------------------------------------------------------------
// bcst_ctrl
// sequencer: edge check, segment search, interpolation divide, result commit
// ----------------------------------------------------------------------------
`default_nettype none

module bcst_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire bcst_pkg::sts_t sts_i,
  output bcst_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_DIVIDE,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.edge_hit ? S_FINISH : S_SEARCH;
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.seg_hit) begin
          state_d = sts_i.seg_simple ? S_FINISH : S_DIVIDE;
        end else if (sts_i.seg_last) begin
          state_d = S_FINISH;
        end
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

>>> sv/bcst_dp.sv
// ----------------------------------------------------------------------------
// bcst_dp
// sample registers, curve walk, shift-subtract divider, state and result
// ----------------------------------------------------------------------------
`default_nettype none

module bcst_dp #(
  parameter int CURVE_POINTS = bcst_pkg::CURVE_POINTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [bcst_pkg::IN_W-1:0]  in_data_i,
  output logic      [bcst_pkg::OUT_W-1:0] out_data_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  input  wire bcst_pkg::cfg_t             cfg_i,
  input  wire bcst_pkg::cmd_t             cmd_i,
  output bcst_pkg::sts_t                  sts_o
);

  localparam int MV_W   = bcst_pkg::MV_W;
  localparam int PCT_W  = bcst_pkg::PCT_W;
  localparam int IDX_W  = bcst_pkg::IDX_W;
  localparam int PROD_W = bcst_pkg::PROD_W;
  localparam int DCNT_W = bcst_pkg::DCNT_W;
  localparam int NPTS   = (CURVE_POINTS > bcst_pkg::CURVE_SLOTS) ? bcst_pkg::CURVE_SLOTS :
                          (CURVE_POINTS < 2) ? 2 : CURVE_POINTS;
  localparam logic [IDX_W-1:0]  LAST_PT  = IDX_W'(NPTS - 1);
  localparam logic [IDX_W-1:0]  LAST_SEG = IDX_W'(NPTS - 2);
  localparam logic [DCNT_W-1:0] DCNT_TOP = DCNT_W'(bcst_pkg::DIV_STEPS - 1);

  // captured sample
  logic [MV_W-1:0]  bat_q, usbv_q, sys_q;
  logic [1:0]       cst_q;
  logic             en_q;

  // curve walk and divider
  logic [IDX_W-1:0]  idx_q;
  logic [PROD_W-1:0] rem_q, dvs_q;
  logic [PCT_W-1:0]  quo_q, lp_q, est_q;
  logic [DCNT_W-1:0] dcnt_q;

  // tracked state and output register
  logic [PCT_W-1:0]             held_q;
  logic                         was_q;
  logic                         out_valid_q;
  logic [bcst_pkg::OUT_W-1:0]   out_data_q;

  // segment under test
  logic [IDX_W-1:0] idx_nx;
  logic [MV_W-1:0]  hv, lv, span;
  logic [PCT_W-1:0] hp, lp;
  logic             top_hit, bot_hit, seg_hit, seg_simple;
  logic [PROD_W-1:0] prod;

  assign idx_nx     = idx_q + IDX_W'(1);
  assign hv         = bcst_pkg::curve_mv(idx_q);
  assign lv         = bcst_pkg::curve_mv(idx_nx);
  assign hp         = bcst_pkg::curve_pct(idx_q);
  assign lp         = bcst_pkg::curve_pct(idx_nx);
  assign span       = hv - lv;
  assign top_hit    = bat_q >= bcst_pkg::curve_mv('0);
  assign bot_hit    = bat_q <= bcst_pkg::curve_mv(LAST_PT);
  assign seg_hit    = (bat_q <= hv) && (bat_q >= lv);
  assign seg_simple = (span == '0) || (hp < lp);
  assign prod       = PROD_W'(bat_q - lv) * PROD_W'(hp - lp);

  // divider step: one quotient bit per cycle
  logic              div_bit;
  logic [PCT_W-1:0]  quo_d;

  assign div_bit = rem_q >= dvs_q;
  assign quo_d   = {quo_q[PCT_W-2:0], div_bit};

  // result of the committed sample
  logic                  usb, batp, done;
  logic [PCT_W-1:0]      held_n, pct, capped;
  bcst_pkg::charge_cmd_e cmd;

  assign usb    = usbv_q >= cfg_i.usb_present_mv;
  assign batp   = (bat_q >= cfg_i.battery_min_mv) && (bat_q <= cfg_i.battery_max_mv);
  assign done   = (cst_q == bcst_pkg::CHG_DONE);
  assign capped = (est_q > cfg_i.charge_start_cap) ? cfg_i.charge_start_cap : est_q;

  always_comb begin
    if (usb && batp) begin
      cmd = en_q ? bcst_pkg::CMD_NONE : bcst_pkg::CMD_ENABLE;
    end else if (!batp && en_q) begin
      cmd = bcst_pkg::CMD_DISABLE;
    end else begin
      cmd = bcst_pkg::CMD_NONE;
    end
  end

  always_comb begin
    held_n = held_q;
    pct    = held_q;
    if (!batp) begin
      held_n = '0;
      pct    = '0;
    end else if (!usb) begin
      if (held_q == '0) begin
        held_n = est_q;
      end else if (!was_q && (est_q < held_q)) begin
        held_n = held_q - PCT_W'(1);
      end
      pct = held_n;
    end else if (done) begin
      pct = bcst_pkg::PCT_FULL;
    end else begin
      if (held_q == '0) begin
        held_n = capped;
      end
      pct = held_n;
    end
  end

  // sample capture and curve evaluation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bat_q  <= in_data_i[MV_W-1:0];
      usbv_q <= in_data_i[2*MV_W-1:MV_W];
      sys_q  <= in_data_i[3*MV_W-1:2*MV_W];
      cst_q  <= in_data_i[3*MV_W+1:3*MV_W];
      en_q   <= in_data_i[3*MV_W+2];
      idx_q  <= '0;
    end
    if (cmd_i.check) begin
      est_q <= top_hit ? bcst_pkg::curve_pct('0) : bcst_pkg::curve_pct(LAST_PT);
    end
    if (cmd_i.search) begin
      if (seg_hit) begin
        est_q  <= lp;
        lp_q   <= lp;
        rem_q  <= prod;
        dvs_q  <= PROD_W'(span) << (bcst_pkg::DIV_STEPS - 1);
        quo_q  <= '0;
        dcnt_q <= DCNT_TOP;
      end else begin
        est_q <= '0;
        idx_q <= idx_nx;
      end
    end
    if (cmd_i.div_step) begin
      if (div_bit) begin
        rem_q <= rem_q - dvs_q;
      end
      dvs_q  <= dvs_q >> 1;
      quo_q  <= quo_d;
      dcnt_q <= dcnt_q - DCNT_W'(1);
      est_q  <= lp_q + quo_d;
    end
    if (cmd_i.commit) begin
      // charge_command, usb, battery, charging, done, percent, low, critical, system
      out_data_q <= bcst_pkg::OUT_W'({
        sys_q,
        batp && !usb && (pct <= cfg_i.critical_percent),
        batp && !usb && (pct <= cfg_i.low_percent),
        pct,
        usb && done,
        usb && ((cst_q == bcst_pkg::CHG_PRE) || (cst_q == bcst_pkg::CHG_FAST)),
        batp,
        usb,
        cmd
      });
    end
  end

  // tracked state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      was_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        held_q      <= held_n;
        was_q       <= usb;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // status to the controller
  assign sts_o.edge_hit   = top_hit || bot_hit;
  assign sts_o.seg_hit    = seg_hit;
  assign sts_o.seg_simple = seg_simple;
  assign sts_o.seg_last   = (idx_q == LAST_SEG);
  assign sts_o.div_last   = (dcnt_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> sv/battery_charge_state_tracker_top.sv
// ----------------------------------------------------------------------------
// battery_charge_state_tracker_top
// classifies usb and battery presence, issues charger commands and tracks
// a battery percentage from a piecewise-linear voltage curve
//
//   port group   direction  carries
//   s_axis_*     in         one measurement sample per request
//   m_axis_*     out        one status result per sample
//   apb          in/out     six configuration registers at 4*i
//
// after acceptance a sample gets an edge check, then, unless it lies at or
// beyond a curve end, a search step per segment walked and, for a sloped
// segment, the one-bit-per-cycle interpolation divider; a commit that waits
// for a free result register ends it; the next sample is taken the cycle after.
// one sample is in work at a time; the result register lets the next
// sample be taken while a result still waits on m_axis_tready.
// reset is asynchronous, active low, and clears state and pending results.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_charge_state_tracker_top #(
  parameter int CURVE_POINTS = bcst_pkg::CURVE_POINTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // battery_mv[13:0], usb_mv[27:14], system_mv[41:28],
  // charger_state[43:42], charger_enabled[44]
  input  wire logic [bcst_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // charge_command[1:0], usb_present[2], battery_present[3], is_charging[4],
  // charge_done[5], percent[12:6], low_flag[13], critical_flag[14],
  // system_mv_out[28:15]
  output logic      [bcst_pkg::OUT_W-1:0]  m_axis_tdata,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bcst_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bcst_pkg::DATA_W-1:0] pwdata,
  output logic      [bcst_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  bcst_pkg::cfg_t cfg;
  bcst_pkg::cmd_t cmd;
  bcst_pkg::sts_t sts;

  // configuration registers
  bcst_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  bcst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  bcst_dp #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

>>> sv/bcst_checker.sv
// ----------------------------------------------------------------------------
// bcst_checker
// port-level checks on the tracker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_charge_state_tracker_top_assert.svh"

module bcst_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [bcst_pkg::OUT_W-1:0]  m_axis_tdata
);

  // result fields
  logic [1:0]                 cmd_code;
  logic                       usb;
  logic                       bat;
  logic [bcst_pkg::PCT_W-1:0] pct;
  logic                       low;
  logic                       crit;

  assign cmd_code = m_axis_tdata[1:0];
  assign usb      = m_axis_tdata[2];
  assign bat      = m_axis_tdata[3];
  assign pct      = m_axis_tdata[12:6];
  assign low      = m_axis_tdata[13];
  assign crit     = m_axis_tdata[14];

  // a stalled result stays offered
  `BCST_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")

  // percentage never exceeds full scale
  `BCST_ASSERT(a_pct_range, m_axis_tvalid |-> pct <= bcst_pkg::PCT_FULL, "percent above 100")

  // no battery reads as empty
  `BCST_ASSERT(a_no_bat_zero, m_axis_tvalid && !bat |-> pct == '0, "percent without battery")

  // low and critical only on battery alone
  `BCST_ASSERT(a_flags_bat, m_axis_tvalid && (low || crit) |-> bat && !usb, "flag off battery")

  // charge command code stays in range
  `BCST_ASSERT(a_cmd_code, m_axis_tvalid |-> cmd_code <= 2'(bcst_pkg::CMD_DISABLE), "bad command")

endmodule

bind battery_charge_state_tracker_top bcst_checker u_bcst_checker (.*);

`default_nettype wire
